// ----- src/lnu_pkg.sv -----
// ----------------------------------------------------------------------------
// LIF neuron update package
// Shared widths, constants, register indexes, sequencer states and helpers
// for the leaky integrate-and-fire neuron update unit.
// ----------------------------------------------------------------------------
package lnu_pkg;

  // Neuron store geometry.
  localparam int unsigned Neurons = 1024;
  localparam int unsigned AddrW   = $clog2(Neurons);

  // Field widths.
  localparam int unsigned IdxW  = 10;
  localparam int unsigned CurW  = 32;
  localparam int unsigned VoltW = 16;
  localparam int unsigned RefW  = 8;
  localparam int unsigned DtW   = 16;
  localparam int unsigned LfsrW = 16;

  // Stream word widths, padded to whole bytes.
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 40;

  // Configuration port.
  localparam int unsigned CfgAddrW = 1;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_DT_OVER_TAU_RC   = 1'b0,
    CFG_REFRACTORY_TICKS = 1'b1
  } cfg_reg_e;

  // Reset values and arithmetic constants.
  localparam logic [DtW-1:0]   DtReset   = 16'd1638;
  localparam logic [RefW-1:0]  RefReset  = 8'd2;
  localparam logic [LfsrW-1:0] LfsrReset = 16'h0001;
  localparam logic [LfsrW-1:0] LfsrTaps  = 16'hB400;
  localparam logic [31:0]      OneFix    = 32'h0000_8000;
  localparam logic [31:0]      Int32Max  = 32'h7fff_ffff;
  localparam logic [31:0]      Int32Min  = 32'h8000_0000;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_UPDATE,
    S_PERTURB,
    S_FIRE,
    S_DONE
  } state_e;

  // One entry of the neuron store.
  typedef struct packed {
    logic [VoltW-1:0] volt;
    logic [RefW-1:0]  refr;
  } nstate_t;

  // One result word before it goes to the output register.
  typedef struct packed {
    logic [RefW-1:0]  refr;
    logic [VoltW-1:0] volt;
    logic             spiked;
  } result_t;

  // Next step of the perturbation LFSR: the state shifted right, XORed with the taps masked by the inverted state.
  function automatic logic [LfsrW-1:0] lfsr_next(input logic [LfsrW-1:0] cur);
    return (cur >> 1) ^ (~cur & LfsrTaps);
  endfunction

endpackage

// ----- src/lif_neuron_update_unit.sv -----
// ----------------------------------------------------------------------------
// LIF neuron update unit
// Leaky integrate-and-fire update of one stored neuron per input word, using
// one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// After reset the unit first clears its 1024-entry neuron store, one entry per
// cycle, and takes no input word until that sweep ends; configuration
// writes are taken during that time. Each input word then occupies the
// sequencer alone: a refractory neuron (or an index beyond the store) passes
// through S_LOAD to S_DONE, a normal update through S_LOAD, S_UPDATE and
// S_PERTURB, and a spiking update through S_FIRE as well, since the voltage step
// and the perturbation term share one 33x17 multiplier and each product is
// registered before use. The next word is accepted in the cycle after the
// result has moved to the output register, which then holds it until the
// downstream side takes it.

module lif_neuron_update_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [lnu_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [lnu_pkg::CfgDataW-1:0] cfg_wdata_i,
  // Input stream.
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // tdata: neuron_index [9:0], membrane_current [41:10], zero [47:42]
  input  logic [lnu_pkg::InDataW-1:0]  s_axis_tdata_i,
  // Output stream.
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // tdata: out_neuron_index [9:0], spiked [10], new_voltage [26:11],
  //        refractory_left [34:27], zero [39:35]
  output logic [lnu_pkg::OutDataW-1:0] m_axis_tdata_o
);

  // Sequencer and control registers.
  lnu_pkg::state_e              state_q, state_d;
  logic [lnu_pkg::AddrW-1:0]    clr_q, clr_d;
  logic [lnu_pkg::LfsrW-1:0]    lfsr_q, lfsr_d;
  logic [lnu_pkg::DtW-1:0]      dt_q;
  logic [lnu_pkg::RefW-1:0]     refr_ticks_q;
  logic                         m_valid_q, m_valid_d;

  // Payload registers.
  logic [lnu_pkg::IdxW-1:0]     idx_q, idx_d;
  logic signed [lnu_pkg::CurW-1:0] cur_q, cur_d;
  logic signed [49:0]           prod_q;
  logic [31:0]                  delta_q, delta_d;
  logic [31:0]                  vnew_q, vnew_d;
  lnu_pkg::result_t             res_q, res_d;
  logic [lnu_pkg::IdxW-1:0]     out_idx_q;
  lnu_pkg::result_t             out_res_q;

  // Neuron store ports.
  lnu_pkg::nstate_t             mem [lnu_pkg::Neurons];
  lnu_pkg::nstate_t             rd_q;
  logic                         mem_we, mem_re;
  logic [lnu_pkg::AddrW-1:0]    mem_wa, mem_ra;
  lnu_pkg::nstate_t             mem_wd;

  // Shared multiplier.
  logic signed [32:0]           mul_a;
  logic signed [16:0]           mul_b;
  logic signed [49:0]           prod;
  logic                         prod_en;

  // Datapath terms.
  logic                         in_range;
  logic signed [32:0]           diff;
  logic signed [34:0]           prod_sh;
  logic [31:0]                  delta_sat;
  logic signed [33:0]           vsum;
  logic [31:0]                  vclamp;
  logic signed [34:0]           thresh;
  logic                         cut;
  logic [lnu_pkg::RefW-1:0]     refr_dec;
  logic                         out_load;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q         <= lnu_pkg::DtReset;
      refr_ticks_q <= lnu_pkg::RefReset;
    end else if (cfg_we_i) begin
      case (lnu_pkg::cfg_reg_e'(cfg_addr_i))
        lnu_pkg::CFG_DT_OVER_TAU_RC:   dt_q         <= cfg_wdata_i;
        lnu_pkg::CFG_REFRACTORY_TICKS: refr_ticks_q <= cfg_wdata_i[lnu_pkg::RefW-1:0];
        default: ;
      endcase
    end
  end

  // Neuron store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  // Shared multiplier: voltage step first, perturbation term after a spike.
  assign mul_a = (state_q == lnu_pkg::S_PERTURB) ? {delta_q[31], delta_q} : diff;
  assign mul_b = (state_q == lnu_pkg::S_PERTURB) ? {2'b00, lfsr_q[14:0]}
                                                 : {1'b0, dt_q};
  assign prod  = mul_a * mul_b;

  // Arithmetic around the product.
  assign in_range = ({1'b0, idx_q} < (lnu_pkg::IdxW + 1)'(lnu_pkg::Neurons));
  assign diff     = {cur_q[31], cur_q} - {17'b0, rd_q.volt};
  assign prod_sh  = prod_q[49:15];

  // Saturate the shifted product to the signed 32-bit range.
  always_comb begin
    if (!prod_sh[34] && (prod_sh[33:31] != 3'b000)) begin
      delta_sat = lnu_pkg::Int32Max;
    end else if (prod_sh[34] && (prod_sh[33:31] != 3'b111)) begin
      delta_sat = lnu_pkg::Int32Min;
    end else begin
      delta_sat = prod_sh[31:0];
    end
  end

  // New voltage, floored at zero and capped at the largest positive value.
  assign vsum = {18'b0, rd_q.volt} + {{2{delta_q[31]}}, delta_q};
  always_comb begin
    if (vsum[33]) begin
      vclamp = 32'b0;
    end else if (vsum[32:31] != 2'b00) begin
      vclamp = lnu_pkg::Int32Max;
    end else begin
      vclamp = vsum[31:0];
    end
  end

  // Perturbation: a product below the excess over threshold shortens a nonzero count by one tick.
  assign thresh   = {3'b000, vnew_q} - {3'b000, lnu_pkg::OneFix};
  assign cut      = (prod_sh < thresh) && (refr_ticks_q != '0);
  assign refr_dec = refr_ticks_q - lnu_pkg::RefW'(cut);

  // State and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lnu_pkg::S_CLEAR;
      clr_q     <= '0;
      lfsr_q    <= lnu_pkg::LfsrReset;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      lfsr_q    <= lfsr_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    cur_q   <= cur_d;
    delta_q <= delta_d;
    vnew_q  <= vnew_d;
    res_q   <= res_d;
    if (prod_en) begin
      prod_q <= prod;
    end
    if (out_load) begin
      out_idx_q <= idx_q;
      out_res_q <= res_q;
    end
  end

  // Sequencer: next state, store access and result capture.
  always_comb begin
    state_d         = state_q;
    clr_d           = clr_q;
    lfsr_d          = lfsr_q;
    idx_d           = idx_q;
    cur_d           = cur_q;
    delta_d         = delta_q;
    vnew_d          = vnew_q;
    res_d           = res_q;
    mem_we          = 1'b0;
    mem_wa          = idx_q[lnu_pkg::AddrW-1:0];
    mem_wd          = '0;
    mem_re          = 1'b0;
    mem_ra          = s_axis_tdata_i[lnu_pkg::AddrW-1:0];
    prod_en         = 1'b0;
    out_load        = 1'b0;
    s_axis_tready_o = 1'b0;

    case (state_q)
      // Sweep the store to zero after reset.
      lnu_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        clr_d  = clr_q + 1'b1;
        if (clr_q == lnu_pkg::AddrW'(lnu_pkg::Neurons - 1)) begin
          state_d = lnu_pkg::S_IDLE;
        end
      end

      // Take a word and start the store read.
      lnu_pkg::S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          idx_d   = s_axis_tdata_i[lnu_pkg::IdxW-1:0];
          cur_d   = s_axis_tdata_i[lnu_pkg::IdxW +: lnu_pkg::CurW];
          mem_re  = 1'b1;
          state_d = lnu_pkg::S_LOAD;
        end
      end

      // Out-of-range indexes give a zero result; refractory neurons only count down; others start the voltage step.
      lnu_pkg::S_LOAD: begin
        if (!in_range) begin
          res_d   = '0;
          state_d = lnu_pkg::S_DONE;
        end else if (rd_q.refr != '0) begin
          mem_we      = 1'b1;
          mem_wd.volt = rd_q.volt;
          mem_wd.refr = rd_q.refr - 1'b1;
          res_d.spiked = 1'b0;
          res_d.volt   = rd_q.volt;
          res_d.refr   = rd_q.refr - 1'b1;
          state_d      = lnu_pkg::S_DONE;
        end else begin
          prod_en = 1'b1;
          state_d = lnu_pkg::S_UPDATE;
        end
      end

      // Saturate the step into delta_q; the clamped sum uses delta_q, so it follows in S_PERTURB.
      lnu_pkg::S_UPDATE: begin
        delta_d = delta_sat;
        state_d = lnu_pkg::S_PERTURB;
      end

      // Register the voltage in vnew; multiply delta by the LFSR fraction if spiking, else store it.
      lnu_pkg::S_PERTURB: begin
        vnew_d = vclamp;
        if (vclamp > lnu_pkg::OneFix) begin
          prod_en = 1'b1;
          state_d = lnu_pkg::S_FIRE;
        end else begin
          mem_we       = 1'b1;
          mem_wd.volt  = vclamp[lnu_pkg::VoltW-1:0];
          mem_wd.refr  = '0;
          res_d.spiked = 1'b0;
          res_d.volt   = vclamp[lnu_pkg::VoltW-1:0];
          res_d.refr   = '0;
          state_d      = lnu_pkg::S_DONE;
        end
      end

      // Spike: clear the voltage, load the count and step the LFSR.
      lnu_pkg::S_FIRE: begin
        mem_we       = 1'b1;
        mem_wd.volt  = '0;
        mem_wd.refr  = refr_dec;
        lfsr_d       = lnu_pkg::lfsr_next(lfsr_q);
        res_d.spiked = 1'b1;
        res_d.volt   = '0;
        res_d.refr   = refr_dec;
        state_d      = lnu_pkg::S_DONE;
      end

      // Hand the result to the output register once it is free.
      lnu_pkg::S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = lnu_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = lnu_pkg::S_IDLE;
      end
    endcase
  end

  // Output register valid.
  always_comb begin
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {5'b0, out_res_q.refr, out_res_q.volt, out_res_q.spiked,
                            out_idx_q};

`ifndef SYNTH
  // The unit works on one word at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while a word is in flight");

  // A spiking result always reports a cleared voltage.
  a_spike_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[10]) |-> (m_axis_tdata_o[26:11] == '0))
    else $error("spike with nonzero voltage");

  // A stored voltage never exceeds the firing threshold.
  a_volt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ({16'b0, m_axis_tdata_o[26:11]} <= lnu_pkg::OneFix))
    else $error("reported voltage above threshold");

  // The perturbation LFSR never locks up at zero.
  a_lfsr_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0)
    else $error("perturbation LFSR reached zero");
`endif

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LIF neuron update unit testbench
// Streams neuron words into the unit and checks every update word that comes
// back against a cycle-free model of the neuron stores, the refractory
// counters and the perturbation LFSR. A short table of directed words comes
// first, then several phases of random words under changing register settings,
// with random sender bursts, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;

  // Timing and run length.
  localparam int HalfPeriod      = 2;
  localparam int ResetCycles     = 9;
  localparam int SettleCycles    = 8;
  localparam int DrainCycles     = 16;
  localparam int HoldCycles      = 400;
  localparam int WatchdogLimit   = 5000;
  localparam int RandPhases      = 8;
  localparam int WordsPerPhase   = 240;
  localparam int PoolSize        = 8;
  localparam int MaxReported     = 10;

  // Model arithmetic constants in 64-bit signed form.
  localparam longint VoltOne = 64'sd32768;
  localparam longint SatMax  = 64'sd2147483647;
  localparam longint SatMin  = -64'sd2147483648;

  // One update word as it leaves the unit.
  typedef struct packed {
    logic [lnu_pkg::IdxW-1:0]  idx;
    logic                      spiked;
    logic [lnu_pkg::VoltW-1:0] volt;
    logic [lnu_pkg::RefW-1:0]  refr;
  } neuron_result_t;

  // Directed stimulus rows: a neuron word or a register write.
  typedef enum logic [1:0] {
    ROW_WORD,
    ROW_DT,
    ROW_REF
  } row_kind_e;

  typedef struct packed {
    row_kind_e                 kind;
    logic [lnu_pkg::IdxW-1:0]  idx;
    logic [lnu_pkg::CurW-1:0]  data;
    logic                      typed;
    logic                      spiked;
    logic [lnu_pkg::VoltW-1:0] volt;
    logic [lnu_pkg::RefW-1:0]  refr;
  } stim_row_t;

  // Receiver stall styles.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_PATTERN,
    RX_SPARSE
  } rx_mode_e;

  // DUT signals.
  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [lnu_pkg::CfgAddrW-1:0] cfg_addr_i = '0;
  logic [lnu_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                         s_axis_tvalid_i = 1'b0;
  logic                         s_axis_tready_o;
  // tdata: neuron_index [9:0], membrane_current [41:10], zero [47:42]
  logic [lnu_pkg::InDataW-1:0]  s_axis_tdata_i = '0;
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i = 1'b0;
  // tdata: out_neuron_index [9:0], spiked [10], new_voltage [26:11],
  //        refractory_left [34:27], zero [39:35]
  logic [lnu_pkg::OutDataW-1:0] m_axis_tdata_o;

  // Model state.
  logic [lnu_pkg::VoltW-1:0] model_volt [0:lnu_pkg::Neurons-1];
  logic [lnu_pkg::RefW-1:0]  model_refr [0:lnu_pkg::Neurons-1];
  logic [lnu_pkg::LfsrW-1:0] model_lfsr;
  logic [lnu_pkg::DtW-1:0]   model_dt;
  logic [lnu_pkg::RefW-1:0]  model_ticks;

  // Scoreboard and pacing state.
  neuron_result_t expected_updates [$];
  stim_row_t      directed_rows [$];
  int unsigned    mismatch_cnt = 0;
  int unsigned    stuck_cycles = 0;
  int             burst_left = 0;
  bit             no_gaps = 1'b0;
  bit             hold_req = 1'b0;
  int             hold_left = 0;
  rx_mode_e       rx_mode = RX_ALWAYS;
  int             rx_mode_left = 0;
  logic [15:0]    stall_pat = 16'h0;

  lif_neuron_update_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Computes the update of one neuron and advances the model state.
  function automatic neuron_result_t predict_update(
      input logic [lnu_pkg::IdxW-1:0] idx,
      input logic signed [lnu_pkg::CurW-1:0] cur);
    neuron_result_t res;
    longint         volt_l;
    longint         delta;
    longint         frac;
    logic [lnu_pkg::RefW-1:0] cnt;
    res.idx    = idx;
    res.spiked = 1'b0;
    res.volt   = '0;
    res.refr   = '0;
    if (model_refr[idx] != '0) begin
      // A refractory neuron only counts down and keeps its voltage.
      model_refr[idx] = model_refr[idx] - 1'b1;
      res.volt = model_volt[idx];
      res.refr = model_refr[idx];
    end else begin
      volt_l = longint'({48'd0, model_volt[idx]});
      delta  = ((longint'(cur) - volt_l) * longint'({48'd0, model_dt})) >>> 15;
      if (delta > SatMax) delta = SatMax;
      if (delta < SatMin) delta = SatMin;
      volt_l = volt_l + delta;
      if (volt_l < 0) volt_l = 0;
      if (volt_l > SatMax) volt_l = SatMax;
      if (volt_l > VoltOne) begin
        // Spike: clear the voltage and load the count, maybe one tick short.
        frac = longint'({49'd0, model_lfsr[14:0]});
        cnt  = model_ticks;
        if ((((frac * delta) >>> 15) < (volt_l - VoltOne)) && cnt != '0) begin
          cnt = cnt - 1'b1;
        end
        model_lfsr      = (model_lfsr >> 1) ^ (~model_lfsr & lnu_pkg::LfsrTaps);
        model_volt[idx] = '0;
        model_refr[idx] = cnt;
        res.spiked      = 1'b1;
        res.refr        = cnt;
      end else begin
        model_volt[idx] = volt_l[lnu_pkg::VoltW-1:0];
        res.volt        = volt_l[lnu_pkg::VoltW-1:0];
      end
    end
    return res;
  endfunction

  // Offers one neuron word, waits for it to be taken and records its update.
  // Starts and ends at a falling edge; the valid stays high on return.
  task automatic put_word(input logic [lnu_pkg::IdxW-1:0] idx,
                          input logic [lnu_pkg::CurW-1:0] cur,
                          input bit typed, input neuron_result_t typed_res);
    neuron_result_t res;
    s_axis_tdata_i  <= {{(lnu_pkg::InDataW - lnu_pkg::IdxW - lnu_pkg::CurW){1'b0}},
                        cur, idx};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    res = predict_update(idx, cur);
    expected_updates.push_back(typed ? typed_res : res);
    @(negedge clk_i);
  endtask

  // Ends a burst now and then with a gap of random length.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      if (!no_gaps) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // Stops sending and waits until every pending update word has arrived.
  task automatic quiesce();
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_updates.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Writes one register while the unit is idle and mirrors it in the model.
  task automatic write_cfg(input lnu_pkg::cfg_reg_e sel,
                           input logic [lnu_pkg::CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= sel;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (sel)
      lnu_pkg::CFG_DT_OVER_TAU_RC:   model_dt = value;
      lnu_pkg::CFG_REFRACTORY_TICKS: model_ticks = value[lnu_pkg::RefW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic add_row(input row_kind_e kind, input logic [lnu_pkg::IdxW-1:0] idx,
                         input logic [lnu_pkg::CurW-1:0] data, input logic typed,
                         input logic spiked, input logic [lnu_pkg::VoltW-1:0] volt,
                         input logic [lnu_pkg::RefW-1:0] refr);
    stim_row_t row;
    row.kind   = kind;
    row.idx    = idx;
    row.data   = data;
    row.typed  = typed;
    row.spiked = spiked;
    row.volt   = volt;
    row.refr   = refr;
    directed_rows.push_back(row);
  endtask

  // Text form of one update word.
  function automatic string res_text(input neuron_result_t r);
    return $sformatf("idx=%0d spiked=%0d volt=0x%04h refr=%0d",
                     r.idx, r.spiked, r.volt, r.refr);
  endfunction

  task automatic report_mismatch(input string what, input neuron_result_t exp_res,
                                 input neuron_result_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxReported) begin
      $display("%0t: %s: expected %s, got %s",
               $realtime, what, res_text(exp_res), res_text(got));
    end
  endtask

  // Compare each update word taken from the unit with the oldest prediction.
  always @(posedge clk_i) begin
    neuron_result_t got;
    neuron_result_t exp_res;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.idx    = m_axis_tdata_o[9:0];
      got.spiked = m_axis_tdata_o[10];
      got.volt   = m_axis_tdata_o[26:11];
      got.refr   = m_axis_tdata_o[34:27];
      if (expected_updates.size() == 0) begin
        report_mismatch("unexpected update word", '0, got);
      end else begin
        exp_res = expected_updates.pop_front();
        if (got.idx != exp_res.idx || got.spiked != exp_res.spiked ||
            got.volt != exp_res.volt || got.refr != exp_res.refr) begin
          report_mismatch("update word mismatch", exp_res, got);
        end
      end
    end
  end

  // Receiver: the stall style is drawn anew when its random run ends; a requested
  // hold-off keeps it stalled for a long stretch.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(20, 120);
        stall_pat    = 16'($urandom);
      end else begin
        rx_mode_left--;
      end
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      case (rx_mode)
        RX_ALWAYS:  m_axis_tready_i <= 1'b1;
        RX_COIN:    m_axis_tready_i <= 1'($urandom_range(0, 1));
        RX_PATTERN: m_axis_tready_i <= stall_pat[0];
        default:    m_axis_tready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    stim_row_t                 row;
    neuron_result_t            typed_res;
    logic [lnu_pkg::IdxW-1:0]  idx;
    logic [lnu_pkg::CurW-1:0]  cur;
    logic [lnu_pkg::IdxW-1:0]  pool [0:PoolSize-1];
    int                        phase;
    int                        k;

    // Model state after reset.
    for (int n = 0; n < lnu_pkg::Neurons; n++) begin
      model_volt[n] = '0;
      model_refr[n] = '0;
    end
    model_lfsr  = lnu_pkg::LfsrReset;
    model_dt    = lnu_pkg::DtReset;
    model_ticks = lnu_pkg::RefReset;

    // Directed table. Typed rows hold results that follow directly from reset
    // values, extreme currents and extreme register settings.
    add_row(ROW_WORD, 10'd5,    32'h0000_0000, 1'b1, 1'b0, 16'd0,     8'd0);
    // Full-scale current spikes at once; the first LFSR fraction cuts one tick.
    add_row(ROW_WORD, 10'd0,    32'h7fff_ffff, 1'b1, 1'b1, 16'd0,     8'd1);
    add_row(ROW_WORD, 10'd0,    32'h1234_5678, 1'b1, 1'b0, 16'd0,     8'd0);
    // Most negative current floors the voltage at zero.
    add_row(ROW_WORD, 10'd0,    32'h8000_0000, 1'b1, 1'b0, 16'd0,     8'd0);
    add_row(ROW_WORD, 10'd1023, 32'h0000_8000, 1'b1, 1'b0, 16'd1638,  8'd0);
    add_row(ROW_WORD, 10'd1023, 32'h0000_8000, 1'b0, 1'b0, 16'd0,     8'd0);
    add_row(ROW_WORD, 10'd1023, 32'h0000_0000, 1'b0, 1'b0, 16'd0,     8'd0);
    add_row(ROW_WORD, 10'd512,  32'h0010_0000, 1'b0, 1'b0, 16'd0,     8'd0);
    add_row(ROW_WORD, 10'd512,  32'h0010_0000, 1'b0, 1'b0, 16'd0,     8'd0);
    // A step of 1.0: the voltage lands exactly on the threshold, then one
    // more step just above it fires.
    add_row(ROW_DT,   10'd0,    32'h0000_8000, 1'b0, 1'b0, 16'd0,     8'd0);
    add_row(ROW_WORD, 10'd7,    32'h0000_8000, 1'b1, 1'b0, 16'h8000,  8'd0);
    add_row(ROW_WORD, 10'd7,    32'h0000_8001, 1'b0, 1'b0, 16'd0,     8'd0);
    // Zero refractory load: the count stays zero and the neuron fires again.
    add_row(ROW_REF,  10'd0,    32'h0000_0000, 1'b0, 1'b0, 16'd0,     8'd0);
    add_row(ROW_WORD, 10'd8,    32'h7fff_ffff, 1'b1, 1'b1, 16'd0,     8'd0);
    add_row(ROW_WORD, 10'd8,    32'h7fff_ffff, 1'b1, 1'b1, 16'd0,     8'd0);
    // Step above 1.0 saturates the delta both ways.
    add_row(ROW_DT,   10'd0,    32'h0000_ffff, 1'b0, 1'b0, 16'd0,     8'd0);
    add_row(ROW_WORD, 10'd9,    32'h7fff_ffff, 1'b1, 1'b1, 16'd0,     8'd0);
    add_row(ROW_WORD, 10'd9,    32'hffff_ffff, 1'b1, 1'b0, 16'd0,     8'd0);
    add_row(ROW_WORD, 10'd9,    32'h8000_0000, 1'b0, 1'b0, 16'd0,     8'd0);
    // Zero step leaves the voltage alone.
    add_row(ROW_DT,   10'd0,    32'h0000_0000, 1'b0, 1'b0, 16'd0,     8'd0);
    add_row(ROW_WORD, 10'd1023, 32'h7fff_ffff, 1'b0, 1'b0, 16'd0,     8'd0);
    // Longest refractory load.
    add_row(ROW_REF,  10'd0,    32'h0000_00ff, 1'b0, 1'b0, 16'd0,     8'd0);
    add_row(ROW_DT,   10'd0,    32'h0000_8000, 1'b0, 1'b0, 16'd0,     8'd0);
    add_row(ROW_WORD, 10'd11,   32'h0001_0000, 1'b0, 1'b0, 16'd0,     8'd0);
    add_row(ROW_WORD, 10'd11,   32'h0000_0000, 1'b0, 1'b0, 16'd0,     8'd0);
    add_row(ROW_WORD, 10'd11,   32'h0000_0000, 1'b0, 1'b0, 16'd0,     8'd0);

    // Reset, released at a falling edge.
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_WORD: begin
          typed_res.idx    = row.idx;
          typed_res.spiked = row.spiked;
          typed_res.volt   = row.volt;
          typed_res.refr   = row.refr;
          put_word(row.idx, row.data, row.typed, typed_res);
          pace_sender();
        end
        ROW_DT: begin
          quiesce();
          write_cfg(lnu_pkg::CFG_DT_OVER_TAU_RC, row.data[lnu_pkg::CfgDataW-1:0]);
        end
        default: begin
          quiesce();
          write_cfg(lnu_pkg::CFG_REFRACTORY_TICKS, row.data[lnu_pkg::CfgDataW-1:0]);
        end
      endcase
    end

    // Random phases, each under its own register setting.
    for (phase = 0; phase < RandPhases; phase++) begin
      quiesce();
      case (phase)
        0:       write_cfg(lnu_pkg::CFG_DT_OVER_TAU_RC, lnu_pkg::DtReset);
        1:       write_cfg(lnu_pkg::CFG_DT_OVER_TAU_RC, 16'h8000);
        2:       write_cfg(lnu_pkg::CFG_DT_OVER_TAU_RC, 16'hffff);
        3:       write_cfg(lnu_pkg::CFG_DT_OVER_TAU_RC, 16'h0000);
        default: write_cfg(lnu_pkg::CFG_DT_OVER_TAU_RC,
                           lnu_pkg::CfgDataW'($urandom_range(200, 20000)));
      endcase
      case (phase)
        0:       write_cfg(lnu_pkg::CFG_REFRACTORY_TICKS, 16'd0);
        1:       write_cfg(lnu_pkg::CFG_REFRACTORY_TICKS, 16'd255);
        2:       write_cfg(lnu_pkg::CFG_REFRACTORY_TICKS,
                           lnu_pkg::CfgDataW'(lnu_pkg::RefReset));
        3:       write_cfg(lnu_pkg::CFG_REFRACTORY_TICKS,
                           lnu_pkg::CfgDataW'($urandom_range(1, 6)));
        default: write_cfg(lnu_pkg::CFG_REFRACTORY_TICKS,
                           lnu_pkg::CfgDataW'($urandom_range(0, 12)));
      endcase

      // A few neurons take most words so that they charge, fire and recover.
      for (k = 0; k < PoolSize; k++) begin
        pool[k] = lnu_pkg::IdxW'($urandom_range(0, lnu_pkg::Neurons - 1));
      end
      pool[0] = '0;
      pool[1] = lnu_pkg::IdxW'(lnu_pkg::Neurons - 1);
      no_gaps = (phase % 3 == 1);

      for (k = 0; k < WordsPerPhase; k++) begin
        if (phase == 4 && k == 80) hold_req = 1'b1;
        if (phase == 6 && k == 120) quiesce();
        if ($urandom_range(0, 3) != 0) idx = pool[$urandom_range(0, PoolSize - 1)];
        else idx = lnu_pkg::IdxW'($urandom_range(0, lnu_pkg::Neurons - 1));
        case ($urandom_range(0, 9))
          0, 1, 2, 3: cur = $urandom_range(32'h0000_6000, 32'h0001_4000);
          4, 5:       cur = $urandom;
          6:          cur = 32'd0 - $urandom_range(0, 32'h0002_0000);
          7:          cur = $urandom_range(0, 32'h0000_8000);
          8:          cur = $urandom >> $urandom_range(0, 31);
          default: begin
            case ($urandom_range(0, 3))
              0:       cur = 32'h7fff_ffff;
              1:       cur = 32'h8000_0000;
              2:       cur = 32'hffff_ffff;
              default: cur = 32'h0000_8001;
            endcase
          end
        endcase
        put_word(idx, cur, 1'b0, '0);
        pace_sender();
      end
    end

    // Drain and finish.
    s_axis_tvalid_i <= 1'b0;
    while (expected_updates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_updates.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/lnu_pkg.sv
src/lif_neuron_update_unit.sv
tb/tb_top.sv
